### design/sgmc_pkg.sv
// ----------------------------------------------------------------------------
// sgmc_pkg
// Shared types, constants and helper functions for the grid move commander.
// ----------------------------------------------------------------------------
package sgmc_pkg;

	localparam int LINE_CHARS_INT = 9;
	localparam int TAKEN_W        = 4;
	localparam logic [TAKEN_W-1:0] LINE_CHARS = TAKEN_W'(LINE_CHARS_INT);

	localparam int ROW_W  = 4;
	localparam int COL_W  = 8;
	localparam int MAG_W  = 9;
	localparam int STEP_W = 16;

	localparam logic [ROW_W-1:0] ROW_COUNT = 4'd10;
	localparam logic [MAG_W-1:0] MAG_MAX   = 9'd511;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UJ    = 8'h4A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LJ    = 8'h6A;

	localparam logic [7:0] STEPS_RESET = 8'd10;
	localparam logic [7:0] COLS_RESET  = 8'd20;

	typedef enum logic {
		REG_STEPS_PER_CELL = 1'b0,
		REG_COLUMN_COUNT   = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_SKIP1,
		PH_SKIP2,
		PH_SIGN,
		PH_DIGITS,
		PH_DONE,
		PH_DEAD
	} phase_t;

	typedef enum logic {
		SEG_ROW,
		SEG_COL
	} seg_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} move_cmd_t;

	typedef struct packed {
		logic      push;
		move_cmd_t cmd;
	} cmd_push_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_HT) || (c == CH_VT) || (c == CH_FF);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

### design/serial_grid_move_commander.sv
// ----------------------------------------------------------------------------
// serial_grid_move_commander
// Byte-serial grid move parser with a row and column segment generator.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle on the s side. Each line
// (ended by CR or LF) of the form "<row letter A-J> <signed column>" that
// lands inside the grid yields up to two move segments on the m side: the
// row move first, then the column move, the last one marked by tlast. The
// parser handles each byte as it arrives; a finished line goes through a
// two-entry command queue, and the segment generator emits at most two
// segments per line, or none for a queued line that moves nothing, so lines
// that arrive faster than the generator drains them fill the queue
// and only then hold s_tready low. Results sit in an output register, so a
// stalled m side does not stop byte intake until the queue is full.
// ----------------------------------------------------------------------------
module serial_grid_move_commander (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] axis, [1] direction, [17:2] step_count, rest zero
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import sgmc_pkg::*;

	logic [7:0]         steps_q, cols_q;
	logic               beat, q_full, head_valid, pop;
	cmd_push_t          push;
	move_cmd_t          head;
	logic               axis, direction;
	logic [STEP_W-1:0]  step_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= STEPS_RESET;
			cols_q  <= COLS_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_STEPS_PER_CELL: steps_q <= cfg_data;
				REG_COLUMN_COUNT:   cols_q  <= cfg_data;
				default:            steps_q <= steps_q;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign beat     = s_tvalid && s_tready;

	sgmc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.beat         (beat),
		.rx_char      (s_tdata),
		.column_count (cols_q),
		.push_out     (push)
	);

	sgmc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_in    (push),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (q_full)
	);

	sgmc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.head_valid     (head_valid),
		.pop            (pop),
		.steps_per_cell (steps_q),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_axis       (axis),
		.out_direction  (direction),
		.out_steps      (step_count),
		.out_last       (m_tlast)
	);

	assign m_tdata = {6'b0, step_count, direction, axis};

	// The parser never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> !q_full)
		else $error("command pushed into a full queue");

	// A segment that does not end its line is always the row move.
	a_row_first: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !m_tdata[0])
		else $error("non-final segment on the column axis");

	// A row segment not ending its line is followed by the column segment.
	a_col_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (head_valid || m_tvalid))
		else $error("column segment lost after a row segment");

	// Moves have a nonzero distance, so steps are nonzero unless the scale is.
	a_nonzero_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && steps_q != 8'd0) |-> (step_count != '0))
		else $error("zero-length segment emitted");

endmodule

### design/sgmc_front.sv
// ----------------------------------------------------------------------------
// sgmc_front
// Line parser: takes one byte per beat and hands each valid line to the queue.
// ----------------------------------------------------------------------------
module sgmc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                beat,
	input  logic [7:0]          rx_char,
	input  logic [7:0]          column_count,
	output sgmc_pkg::cmd_push_t push_out
);
	import sgmc_pkg::*;

	phase_t               phase_q, phase_nxt;
	logic [TAKEN_W-1:0]   taken_q, taken_nxt;
	logic [ROW_W-1:0]     row_q, row_nxt;
	logic                 row_ok_q, row_ok_nxt;
	logic [MAG_W-1:0]     mag_q, mag_nxt;
	logic                 neg_q, neg_nxt;

	logic                 eol;
	logic [MAG_W+3:0]     mag_acc;
	logic [MAG_W-1:0]     mag_add;
	logic [7:0]           letter_off_u, letter_off_l;
	logic                 number, col_ok;

	assign eol = (rx_char == CH_LF) || (rx_char == CH_CR);

	// mag * 10 + digit, saturated so large columns stay out of range.
	assign mag_acc = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1)
		+ {{(MAG_W){1'b0}}, rx_char[3:0]};
	assign mag_add = (mag_acc > {4'b0, MAG_MAX}) ? MAG_MAX : mag_acc[MAG_W-1:0];

	assign letter_off_u = rx_char - CH_UA;
	assign letter_off_l = rx_char - CH_LA;

	always_comb begin
		phase_nxt  = phase_q;
		taken_nxt  = taken_q;
		row_nxt    = row_q;
		row_ok_nxt = row_ok_q;
		mag_nxt    = mag_q;
		neg_nxt    = neg_q;
		if (beat) begin
			if (eol) begin
				if (taken_q != '0) begin
					phase_nxt  = PH_SKIP1;
					taken_nxt  = '0;
					row_nxt    = '0;
					row_ok_nxt = 1'b0;
					mag_nxt    = '0;
					neg_nxt    = 1'b0;
				end
			end else if (taken_q < LINE_CHARS) begin
				taken_nxt = taken_q + 1'b1;
				case (phase_q)
					PH_SKIP1: begin
						if (rx_char == CH_NUL) begin
							phase_nxt = PH_DEAD;
						end else if (!is_blank(rx_char)) begin
							if (rx_char >= CH_UA && rx_char <= CH_UJ) begin
								row_nxt    = letter_off_u[ROW_W-1:0];
								row_ok_nxt = 1'b1;
							end else if (rx_char >= CH_LA && rx_char <= CH_LJ) begin
								row_nxt    = letter_off_l[ROW_W-1:0];
								row_ok_nxt = 1'b1;
							end
							phase_nxt = PH_SKIP2;
						end
					end
					PH_SKIP2: begin
						if (is_blank(rx_char)) begin
							phase_nxt = PH_SKIP2;
						end else if (rx_char == CH_PLUS || rx_char == CH_MINUS) begin
							neg_nxt   = (rx_char == CH_MINUS);
							phase_nxt = PH_SIGN;
						end else if (is_digit(rx_char)) begin
							mag_nxt   = mag_add;
							phase_nxt = PH_DIGITS;
						end else begin
							phase_nxt = PH_DEAD;
						end
					end
					PH_SIGN: begin
						if (is_digit(rx_char)) begin
							mag_nxt   = mag_add;
							phase_nxt = PH_DIGITS;
						end else begin
							phase_nxt = PH_DEAD;
						end
					end
					PH_DIGITS: begin
						if (is_digit(rx_char)) begin
							mag_nxt = mag_add;
						end else begin
							phase_nxt = PH_DONE;
						end
					end
					default: begin
						phase_nxt = phase_q;
					end
				endcase
			end
		end
	end

	// A line counts only with a number, a real row letter and a column in range.
	assign number = (phase_q == PH_DIGITS) || (phase_q == PH_DONE);
	assign col_ok = (!neg_q || mag_q == '0) && (mag_q < {1'b0, column_count});

	always_comb begin
		push_out.push    = beat && eol && (taken_q != '0) && number && row_ok_q
			&& (row_q < ROW_COUNT) && col_ok;
		push_out.cmd.row = row_q;
		push_out.cmd.col = mag_q[COL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SKIP1;
			taken_q  <= '0;
			row_q    <= '0;
			row_ok_q <= 1'b0;
			mag_q    <= '0;
			neg_q    <= 1'b0;
		end else begin
			phase_q  <= phase_nxt;
			taken_q  <= taken_nxt;
			row_q    <= row_nxt;
			row_ok_q <= row_ok_nxt;
			mag_q    <= mag_nxt;
			neg_q    <= neg_nxt;
		end
	end

endmodule

### design/sgmc_queue.sv
// ----------------------------------------------------------------------------
// sgmc_queue
// Short command queue between the parser and the segment generator.
// ----------------------------------------------------------------------------
module sgmc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  sgmc_pkg::cmd_push_t push_in,
	input  logic                pop,
	output sgmc_pkg::move_cmd_t head,
	output logic                head_valid,
	output logic                full
);
	import sgmc_pkg::*;

	move_cmd_t           slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_pop;

	assign head_valid = (count_q != '0);
	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head       = slot_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push_in.push) begin
			slot_q[wr_ptr_q] <= push_in.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_in.push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push_in.push) - QCNT_W'(do_pop);
		end
	end

endmodule

### design/sgmc_back.sv
// ----------------------------------------------------------------------------
// sgmc_back
// Segment generator: turns queued targets into row and column moves.
// ----------------------------------------------------------------------------
module sgmc_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sgmc_pkg::move_cmd_t     head,
	input  logic                    head_valid,
	output logic                    pop,
	input  logic [7:0]              steps_per_cell,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    out_axis,
	output logic                    out_direction,
	output logic [sgmc_pkg::STEP_W-1:0] out_steps,
	output logic                    out_last
);
	import sgmc_pkg::*;

	seg_t               seg_q, seg_nxt;
	logic [ROW_W-1:0]   pos_row_q;
	logic [COL_W-1:0]   pos_col_q;

	logic               valid_q, axis_q, dir_q, last_q;
	logic [STEP_W-1:0]  steps_q;

	logic               slot_free, row_nz, col_nz, do_row, col_phase;
	logic               emit, emit_axis, emit_dir, emit_last;
	logic [COL_W-1:0]   row_dist, col_dist, diff;

	assign slot_free = !valid_q || out_ready;
	assign row_nz    = head.row != pos_row_q;
	assign col_nz    = head.col != pos_col_q;
	assign do_row    = head_valid && (seg_q == SEG_ROW) && row_nz;
	assign col_phase = head_valid && !do_row;

	assign row_dist = (head.row > pos_row_q)
		? {{(COL_W-ROW_W){1'b0}}, head.row - pos_row_q}
		: {{(COL_W-ROW_W){1'b0}}, pos_row_q - head.row};
	assign col_dist = (head.col > pos_col_q) ? head.col - pos_col_q : pos_col_q - head.col;

	// Outputs of the segment sequencer.
	always_comb begin
		emit      = 1'b0;
		emit_axis = 1'b0;
		emit_dir  = 1'b0;
		emit_last = 1'b0;
		diff      = row_dist;
		pop       = 1'b0;
		if (do_row) begin
			emit      = slot_free;
			emit_dir  = head.row > pos_row_q;
			emit_last = !col_nz;
			pop       = slot_free && !col_nz;
		end else if (col_phase) begin
			emit      = slot_free && col_nz;
			emit_axis = 1'b1;
			emit_dir  = head.col > pos_col_q;
			emit_last = 1'b1;
			diff      = col_dist;
			pop       = slot_free || !col_nz;
		end
	end

	// Next state: the column move follows a row move that left one pending.
	always_comb begin
		seg_nxt = seg_q;
		case (seg_q)
			SEG_ROW: begin
				if (do_row && slot_free && col_nz) begin
					seg_nxt = SEG_COL;
				end
			end
			SEG_COL: begin
				if (pop) begin
					seg_nxt = SEG_ROW;
				end
			end
			default: begin
				seg_nxt = SEG_ROW;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q     <= SEG_ROW;
			pos_row_q <= '0;
			pos_col_q <= '0;
			valid_q   <= 1'b0;
		end else begin
			seg_q <= seg_nxt;
			if (emit && !emit_axis) begin
				pos_row_q <= head.row;
			end
			if (emit && emit_axis) begin
				pos_col_q <= head.col;
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			axis_q  <= emit_axis;
			dir_q   <= emit_dir;
			last_q  <= emit_last;
			steps_q <= STEP_W'(diff) * STEP_W'(steps_per_cell);
		end
	end

	assign out_valid     = valid_q;
	assign out_axis      = axis_q;
	assign out_direction = dir_q;
	assign out_steps     = steps_q;
	assign out_last      = last_q;

endmodule
